// ===== rtl/isrch_pkg.sv =====
// Package for the interpolation search engine: field widths, types and defaults.
package isrch_pkg;

  // Fixed payload widths of the channels
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POSITION_W = 10;
  localparam int unsigned COUNT_W    = 11;

  // Defaults for the top-level parameters
  localparam int unsigned STORE_DEPTH_DEF   = 1024;
  localparam int unsigned ELEMENT_WIDTH_DEF = 32;

  // Operation codes of an input item
  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_e;

  typedef logic        [INDEX_W-1:0]    index_t;
  typedef logic signed [VALUE_W-1:0]    value_t;
  typedef logic        [POSITION_W-1:0] position_t;
  typedef logic        [COUNT_W-1:0]    count_t;

endpackage

// ===== rtl/isrch_in_if.sv =====
// Input item channel: load or search requests.
interface isrch_in_if;
  logic                valid;
  logic                ready;
  isrch_pkg::func_e    func;
  isrch_pkg::index_t   index;
  isrch_pkg::value_t   value;

  modport source (output valid, output func, output index, output value, input ready);
  modport sink   (input valid, input func, input index, input value, output ready);
endinterface

// ===== rtl/isrch_out_if.sv =====
// Result item channel: found flag and matching position.
interface isrch_out_if;
  logic                   valid;
  logic                   ready;
  logic                   found;
  isrch_pkg::position_t   position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

// ===== rtl/isrch_cfg_if.sv =====
// Configuration write channel for the element count register.
interface isrch_cfg_if;
  logic                valid;
  logic                ready;
  isrch_pkg::count_t   element_count;

  modport source (output valid, output element_count, input ready);
  modport sink   (input valid, input element_count, output ready);
endinterface

// ===== rtl/interpolation_search.sv =====
// Interpolation search engine over an element store, with bit-serial probe divider.
//
// The block holds STORE_DEPTH signed elements of ELEMENT_WIDTH bits in a memory with
// one write port and one registered read port. A load item writes one element (loads
// at an index beyond the store are dropped) and gives no result. A search item
// gives one result: found and position (position is 0 when not found). The
// search runs over the first element_count entries, which software keeps in
// ascending order; entries read by a search must have been loaded first. Each
// probe reads the low and high bounds, then computes
// low + floor((target - e[low]) * (high - low) / (e[high] - e[low])) in a shared
// add/subtract unit that retires one half step per cycle over the AW =
// ceil(log2(STORE_DEPTH)) bits of the span, then reads the probed entry. A search
// waits in its last step while an earlier result still sits in the output register.
// The input is not ready while a search runs. element_count can be written in
// any cycle and is read as a search starts; values above STORE_DEPTH count as
// STORE_DEPTH.
module interpolation_search #(
  parameter int unsigned STORE_DEPTH   = isrch_pkg::STORE_DEPTH_DEF,
  parameter int unsigned ELEMENT_WIDTH = isrch_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  isrch_in_if.sink             in_i,
  isrch_out_if.source          out_o,
  isrch_cfg_if.sink            cfg_i
);

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned BW = (AW > 1) ? $clog2(AW) : 1;
  localparam int unsigned NW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned LW = AW + 2;
  localparam int unsigned EW = ELEMENT_WIDTH;
  localparam int unsigned DW = EW + 2;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_LOOP  = 10'b00_0000_0010,
    ST_LO    = 10'b00_0000_0100,
    ST_HI    = 10'b00_0000_1000,
    ST_SETUP = 10'b00_0001_0000,
    ST_DIV_A = 10'b00_0010_0000,
    ST_DIV_B = 10'b00_0100_0000,
    ST_PROBE = 10'b00_1000_0000,
    ST_CMP   = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_e;

  // Control state
  state_e                  state_q, state_d;
  logic                    out_valid_q, out_valid_d;
  isrch_pkg::count_t       count_q, count_d;

  // Search datapath
  logic signed [LW-1:0]    low_q, low_d;
  logic signed [LW-1:0]    high_q, high_d;
  logic signed [EW-1:0]    target_q, target_d;
  logic signed [EW-1:0]    el_q, el_d;
  logic signed [EW-1:0]    eh_q, eh_d;
  logic        [EW-1:0]    num_q, num_d;
  logic        [EW-1:0]    den_q, den_d;
  logic        [EW-1:0]    rem_q, rem_d;
  logic        [AW-1:0]    span_q, span_d;
  logic        [AW-1:0]    quo_q, quo_d;
  logic        [BW-1:0]    bit_q, bit_d;
  logic        [AW-1:0]    pos_q, pos_d;
  logic                    res_found_q, res_found_d;
  isrch_pkg::position_t    res_pos_q, res_pos_d;
  logic                    out_found_q, out_found_d;
  isrch_pkg::position_t    out_pos_q, out_pos_d;

  // Element store
  logic        [EW-1:0]    store_q [STORE_DEPTH];
  logic signed [EW-1:0]    rd_q;
  logic        [AW-1:0]    rd_addr;
  logic                    wr_en;
  logic        [AW-1:0]    wr_addr;

  // Shared add/subtract unit
  logic        [EW-1:0]    opb;
  logic        [EW:0]      alt;
  logic signed [DW-1:0]    sum;
  logic                    sub_ok;

  logic                    in_xfer;
  logic signed [EW-1:0]    val_ext;
  logic        [NW-1:0]    n_elems;
  logic        [AW-1:0]    probe_addr;

  assign in_i.ready     = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.found    = out_found_q;
  assign out_o.position = out_pos_q;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign val_ext  = EW'(in_i.value);
  assign wr_addr  = AW'(in_i.index);
  assign wr_en    = in_xfer && (in_i.func == isrch_pkg::FUNC_LOAD)
                    && (32'(in_i.index) < 32'(STORE_DEPTH));

  // Searched length, saturated to the store depth
  always_comb begin
    if (32'(count_q) > 32'(STORE_DEPTH)) begin
      n_elems = NW'(STORE_DEPTH);
    end else begin
      n_elems = NW'(count_q);
    end
  end

  // Divider step: doubling step adds the remainder, span step adds the numerator
  assign opb    = (state_q == ST_DIV_B) ? num_q : rem_q;
  assign alt    = (EW+1)'(rem_q) + (EW+1)'(opb);
  assign sum    = $signed(DW'(alt)) - $signed(DW'(den_q));
  assign sub_ok = !sum[DW-1];

  assign probe_addr = low_q[AW-1:0] + quo_q;

  // Memory read address by phase
  always_comb begin
    case (state_q)
      ST_LO:    rd_addr = high_q[AW-1:0];
      ST_PROBE: rd_addr = probe_addr;
      default:  rd_addr = low_q[AW-1:0];
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    low_d       = low_q;
    high_d      = high_q;
    target_d    = target_q;
    el_d        = el_q;
    eh_d        = eh_q;
    num_d       = num_q;
    den_d       = den_q;
    rem_d       = rem_q;
    span_d      = span_q;
    quo_d       = quo_q;
    bit_d       = bit_q;
    pos_d       = pos_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;

    if (cfg_i.valid) begin
      count_d = cfg_i.element_count;
    end

    // result transfer frees the output register
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_i.func == isrch_pkg::FUNC_SEARCH)) begin
          target_d = val_ext;
          low_d    = '0;
          high_d   = LW'(n_elems) - LW'(1);
          state_d  = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (low_q > high_q) begin
          res_found_d = 1'b0;
          res_pos_d   = '0;
          state_d     = ST_DONE;
        end else begin
          state_d = ST_LO;
        end
      end
      ST_LO: begin
        el_d = rd_q;
        if (target_q < rd_q) begin
          res_found_d = 1'b0;
          res_pos_d   = '0;
          state_d     = ST_DONE;
        end else begin
          state_d = ST_HI;
        end
      end
      ST_HI: begin
        eh_d = rd_q;
        if (target_q > rd_q) begin
          res_found_d = 1'b0;
          res_pos_d   = '0;
          state_d     = ST_DONE;
        end else begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (el_q == eh_q) begin
          // flat range: a match only at the low bound
          res_found_d = (el_q == target_q);
          res_pos_d   = (el_q == target_q) ? isrch_pkg::POSITION_W'(low_q[AW-1:0]) : '0;
          state_d     = ST_DONE;
        end else begin
          num_d   = EW'(target_q - el_q);
          den_d   = EW'(eh_q - el_q);
          span_d  = AW'(high_q - low_q);
          rem_d   = '0;
          quo_d   = '0;
          bit_d   = BW'(AW - 1);
          state_d = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        rem_d = sub_ok ? sum[EW-1:0] : alt[EW-1:0];
        quo_d = (quo_q << 1) | AW'(sub_ok);
        if (span_q[bit_q]) begin
          state_d = ST_DIV_B;
        end else if (bit_q == '0) begin
          state_d = ST_PROBE;
        end else begin
          bit_d = bit_q - BW'(1);
        end
      end
      ST_DIV_B: begin
        rem_d = sub_ok ? sum[EW-1:0] : alt[EW-1:0];
        quo_d = quo_q + AW'(sub_ok);
        if (bit_q == '0) begin
          state_d = ST_PROBE;
        end else begin
          bit_d   = bit_q - BW'(1);
          state_d = ST_DIV_A;
        end
      end
      ST_PROBE: begin
        pos_d   = probe_addr;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (rd_q == target_q) begin
          res_found_d = 1'b1;
          res_pos_d   = isrch_pkg::POSITION_W'(pos_q);
          state_d     = ST_DONE;
        end else begin
          if (rd_q < target_q) begin
            low_d = LW'(pos_q) + LW'(1);
          end else begin
            high_d = LW'(pos_q) - LW'(1);
          end
          state_d = ST_LOOP;
        end
      end
      ST_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_pos_d   = res_pos_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    low_q       <= low_d;
    high_q      <= high_d;
    target_q    <= target_d;
    el_q        <= el_d;
    eh_q        <= eh_d;
    num_q       <= num_d;
    den_q       <= den_d;
    rem_q       <= rem_d;
    span_q      <= span_d;
    quo_q       <= quo_d;
    bit_q       <= bit_d;
    pos_q       <= pos_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
  end

  // Element store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= val_ext;
    end
    rd_q <= store_q[rd_addr];
  end

endmodule
